### rtl/section_occupancy_safe_intervals_defines.svh
// Assertion macros shared by the checker.
`ifndef SECTION_OCCUPANCY_SAFE_INTERVALS_DEFINES_SVH
`define SECTION_OCCUPANCY_SAFE_INTERVALS_DEFINES_SVH

// Checked only while the block is out of reset.
`define SOSI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("section occupancy check failed");

// Checked on every edge, reset included.
`define SOSI_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("section occupancy reset check failed");

`endif

### rtl/sosi_pkg.sv
package sosi_pkg;

    localparam int SEC_W   = 6;
    localparam int TIME_W  = 10;
    localparam int CNT_W   = 10;
    localparam int CAP_W   = 9;
    localparam int ADDR_W  = SEC_W + TIME_W;
    localparam int NUM_W   = 6;

    localparam logic [NUM_W-1:0]  MAX_INTERVALS = 6'd32;
    localparam logic signed [CNT_W:0] SAT_HI = 11'sd256;
    localparam logic signed [CNT_W:0] SAT_LO = -11'sd256;
    localparam logic [TIME_W-1:0] LIMIT_RESET = 10'd1023;

    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_STEP  = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_SAFE  = 3'd3;
    localparam logic [2:0] KIND_CONG  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NONE  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_NEG   = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT, ST_CLEAR, ST_IDLE, ST_DECODE, ST_WR_A, ST_WR_B,
        ST_ACK, ST_SWEEP, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RD_PREV_T, RD_PREV_L, RD_SEC_T, RD_SWEEP
    } rd_sel_t;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        logic       wr_dec;
        logic       prev_set;
        logic       prev_drop;
        logic       sweep_init;
        logic       sweep_step;
        logic       ack;
        logic [1:0] ack_status;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       step_bad;
        logic       cong_bad;
        logic       prev_v;
        logic       prev_eq;
        logic       clr_done;
        logic       sweep_at_end;
        logic       cong_done;
        logic       sweep_stall;
        logic       out_free;
    } stat_t;

    function automatic logic signed [CNT_W-1:0] sat_cnt(input logic signed [CNT_W:0] v);
        logic signed [CNT_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[CNT_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[CNT_W-1:0];
        end else begin
            r = v[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/sosi_ctrl.sv
module sosi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sosi_pkg::stat_t  stat,
    output sosi_pkg::cmd_t   cmd
);

    sosi_pkg::state_t state_reg, state_next;
    logic [1:0]       ack_stat_reg, ack_stat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sosi_pkg::ST_INIT;
            ack_stat_reg <= sosi_pkg::STAT_OK;
        end else begin
            state_reg    <= state_next;
            ack_stat_reg <= ack_stat_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ack_stat_next  = ack_stat_reg;
        cmd            = '0;
        cmd.rd_sel     = sosi_pkg::RD_SWEEP;
        cmd.ack_status = ack_stat_reg;
        in_ready       = 1'b0;
        case (state_reg)
            sosi_pkg::ST_INIT: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_done) begin
                    state_next = sosi_pkg::ST_IDLE;
                end
            end
            sosi_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_done) begin
                    state_next = sosi_pkg::ST_ACK;
                end
            end
            sosi_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sosi_pkg::ST_DECODE;
                end
            end
            sosi_pkg::ST_DECODE: begin
                ack_stat_next = sosi_pkg::STAT_OK;
                case (stat.kind)
                    sosi_pkg::KIND_CLEAR: begin
                        cmd.prev_drop = 1'b1;
                        state_next    = sosi_pkg::ST_CLEAR;
                    end
                    sosi_pkg::KIND_STEP: begin
                        if (stat.step_bad) begin
                            ack_stat_next = sosi_pkg::STAT_RANGE;
                            state_next    = sosi_pkg::ST_ACK;
                        end else if (stat.prev_v && stat.prev_eq) begin
                            state_next = sosi_pkg::ST_ACK;
                        end else if (stat.prev_v) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sosi_pkg::RD_PREV_T;
                            state_next = sosi_pkg::ST_WR_A;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sosi_pkg::RD_SEC_T;
                            state_next = sosi_pkg::ST_WR_B;
                        end
                    end
                    sosi_pkg::KIND_END: begin
                        cmd.prev_drop = 1'b1;
                        if (stat.prev_v) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = sosi_pkg::RD_PREV_L;
                            state_next = sosi_pkg::ST_WR_A;
                        end else begin
                            state_next = sosi_pkg::ST_ACK;
                        end
                    end
                    sosi_pkg::KIND_SAFE: begin
                        cmd.sweep_init = 1'b1;
                        cmd.rd_en      = 1'b1;
                        state_next     = sosi_pkg::ST_SWEEP;
                    end
                    sosi_pkg::KIND_CONG: begin
                        if (stat.cong_bad) begin
                            ack_stat_next = sosi_pkg::STAT_RANGE;
                            state_next    = sosi_pkg::ST_ACK;
                        end else begin
                            cmd.sweep_init = 1'b1;
                            cmd.rd_en      = 1'b1;
                            state_next     = sosi_pkg::ST_SWEEP;
                        end
                    end
                    default: begin
                        state_next = sosi_pkg::ST_IDLE;
                    end
                endcase
            end
            sosi_pkg::ST_WR_A: begin
                // The decrement of the section being left; a step then goes on to the entry.
                cmd.wr_en  = 1'b1;
                cmd.wr_dec = 1'b1;
                if (stat.kind == sosi_pkg::KIND_STEP) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sosi_pkg::RD_SEC_T;
                    state_next = sosi_pkg::ST_WR_B;
                end else begin
                    state_next = sosi_pkg::ST_ACK;
                end
            end
            sosi_pkg::ST_WR_B: begin
                cmd.wr_en    = 1'b1;
                cmd.prev_set = 1'b1;
                state_next   = sosi_pkg::ST_ACK;
            end
            sosi_pkg::ST_ACK: begin
                if (stat.out_free) begin
                    cmd.ack    = 1'b1;
                    state_next = sosi_pkg::ST_IDLE;
                end
            end
            sosi_pkg::ST_SWEEP: begin
                if (stat.kind == sosi_pkg::KIND_SAFE) begin
                    if (!stat.sweep_stall) begin
                        cmd.sweep_step = 1'b1;
                        cmd.rd_en      = 1'b1;
                        if (stat.sweep_at_end) begin
                            state_next = sosi_pkg::ST_FINISH;
                        end
                    end
                end else begin
                    cmd.sweep_step = 1'b1;
                    cmd.rd_en      = 1'b1;
                    if (stat.cong_done) begin
                        state_next = sosi_pkg::ST_FINISH;
                    end
                end
            end
            sosi_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = sosi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sosi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sosi_datapath.sv
module sosi_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sosi_pkg::cmd_t                      cmd,
    output sosi_pkg::stat_t                     stat,
    input  logic [2:0]                          in_kind,
    input  logic [sosi_pkg::SEC_W-1:0]          in_section,
    input  logic [sosi_pkg::TIME_W-1:0]         in_time,
    input  logic [sosi_pkg::CAP_W-1:0]          in_capacity,
    input  logic                                cfg_wr_en,
    input  logic [sosi_pkg::TIME_W-1:0]         cfg_wr_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [1:0]                          out_status,
    output logic [sosi_pkg::TIME_W-1:0]         out_start,
    output logic [sosi_pkg::TIME_W-1:0]         out_end,
    output logic [sosi_pkg::CNT_W-1:0]          out_occ,
    output logic                                out_last,
    output logic                                out_ovf
);

    localparam int DEPTH = 2 ** sosi_pkg::ADDR_W;

    logic signed [sosi_pkg::CNT_W-1:0] mem [DEPTH];

    logic [2:0]                        kind_reg;
    logic [sosi_pkg::SEC_W-1:0]        sec_reg;
    logic [sosi_pkg::TIME_W-1:0]       time_reg;
    logic [sosi_pkg::CAP_W-1:0]        cap_reg;
    logic [sosi_pkg::TIME_W-1:0]       limit_reg;
    logic [sosi_pkg::SEC_W-1:0]        prev_sec_reg;
    logic                              prev_v_reg;
    logic [sosi_pkg::ADDR_W-1:0]       clr_addr_reg;
    logic [sosi_pkg::ADDR_W-1:0]       wr_addr_reg;
    logic signed [sosi_pkg::CNT_W-1:0] rd_data_reg;

    logic [sosi_pkg::TIME_W-1:0]       x_reg;
    logic signed [sosi_pkg::CNT_W-1:0] cnt_reg;
    logic [sosi_pkg::TIME_W-1:0]       start_reg;
    logic [sosi_pkg::NUM_W-1:0]        num_reg;
    logic                              ovf_reg;
    logic                              pend_v_reg;
    logic [sosi_pkg::TIME_W-1:0]       pend_start_reg;
    logic [sosi_pkg::TIME_W-1:0]       pend_end_reg;
    logic signed [sosi_pkg::CNT_W-1:0] pend_occ_reg;

    logic                              out_v_reg;
    logic [1:0]                        out_status_reg;
    logic [sosi_pkg::TIME_W-1:0]       out_start_reg;
    logic [sosi_pkg::TIME_W-1:0]       out_end_reg;
    logic [sosi_pkg::CNT_W-1:0]        out_occ_reg;
    logic                              out_last_reg;
    logic                              out_ovf_reg;

    logic [sosi_pkg::TIME_W-1:0]       lim;
    logic [sosi_pkg::ADDR_W-1:0]       rd_addr;
    logic [sosi_pkg::TIME_W-1:0]       x_rd;
    logic signed [sosi_pkg::CNT_W-1:0] wr_data;
    logic signed [sosi_pkg::CNT_W-1:0] nc;
    logic                              at_end;
    logic                              closing;
    logic                              emit;
    logic                              store;
    logic                              out_free;

    // The effective horizon never drops below one slot.
    assign lim = (limit_reg == '0) ? sosi_pkg::TIME_W'(1) : limit_reg;

    assign x_rd = cmd.sweep_init ? '0 : x_reg + sosi_pkg::TIME_W'(1);

    always_comb begin
        case (cmd.rd_sel)
            sosi_pkg::RD_PREV_T: rd_addr = {prev_sec_reg, time_reg};
            sosi_pkg::RD_PREV_L: rd_addr = {prev_sec_reg, lim};
            sosi_pkg::RD_SEC_T:  rd_addr = {sec_reg, time_reg};
            sosi_pkg::RD_SWEEP:  rd_addr = {sec_reg, x_rd};
            default:             rd_addr = {sec_reg, x_rd};
        endcase
    end

    assign wr_data = sosi_pkg::sat_cnt({rd_data_reg[sosi_pkg::CNT_W-1], rd_data_reg}
                     + (cmd.wr_dec ? -11'sd1 : 11'sd1));

    assign at_end  = (x_reg == lim);
    assign nc      = at_end ? cnt_reg
                   : sosi_pkg::sat_cnt({cnt_reg[sosi_pkg::CNT_W-1], cnt_reg}
                                       + {rd_data_reg[sosi_pkg::CNT_W-1], rd_data_reg});
    // A boundary falls only where the count really changes, and always at the horizon.
    assign closing = at_end || ((x_reg != '0) && (nc != cnt_reg));
    assign emit    = (kind_reg == sosi_pkg::KIND_SAFE) && closing
                   && ($signed({cnt_reg[sosi_pkg::CNT_W-1], cnt_reg})
                       < $signed({2'b00, cap_reg}));
    assign store   = emit && (num_reg < sosi_pkg::MAX_INTERVALS);
    assign out_free = !out_v_reg || out_ready;

    assign stat.kind         = kind_reg;
    assign stat.step_bad     = time_reg > lim;
    assign stat.cong_bad     = time_reg >= lim;
    assign stat.prev_v       = prev_v_reg;
    assign stat.prev_eq      = prev_sec_reg == sec_reg;
    assign stat.clr_done     = &clr_addr_reg;
    assign stat.sweep_at_end = at_end;
    assign stat.cong_done    = x_reg == time_reg;
    assign stat.sweep_stall  = store && pend_v_reg && !out_free;
    assign stat.out_free     = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.wr_en) begin
            mem[wr_addr_reg] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            wr_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= in_kind;
            sec_reg  <= in_section;
            time_reg <= in_time;
            cap_reg  <= in_capacity;
        end
        if (cmd.prev_set) begin
            prev_sec_reg <= sec_reg;
        end
        if (cmd.sweep_init) begin
            x_reg     <= '0;
            cnt_reg   <= '0;
            start_reg <= '0;
        end else if (cmd.sweep_step) begin
            x_reg   <= x_reg + sosi_pkg::TIME_W'(1);
            cnt_reg <= nc;
            if (closing) begin
                start_reg <= x_reg;
            end
            if (store) begin
                pend_start_reg <= start_reg;
                pend_end_reg   <= x_reg;
                pend_occ_reg   <= cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= sosi_pkg::LIMIT_RESET;
            prev_v_reg   <= 1'b0;
            clr_addr_reg <= '0;
            num_reg      <= '0;
            ovf_reg      <= 1'b0;
            pend_v_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.prev_drop) begin
                prev_v_reg <= 1'b0;
            end else if (cmd.prev_set) begin
                prev_v_reg <= 1'b1;
            end
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + sosi_pkg::ADDR_W'(1);
            end
            if (cmd.sweep_init) begin
                num_reg    <= '0;
                ovf_reg    <= 1'b0;
                pend_v_reg <= 1'b0;
            end else if (cmd.sweep_step) begin
                if (store) begin
                    num_reg    <= num_reg + sosi_pkg::NUM_W'(1);
                    pend_v_reg <= 1'b1;
                end else if (emit) begin
                    ovf_reg <= 1'b1;
                end
            end else if (cmd.finish) begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    // Output register; the held interval moves out only when a later one replaces it
    // or the sweep ends, so that the final one can carry the last flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (cmd.ack || cmd.finish || (cmd.sweep_step && store && pend_v_reg)) begin
            out_v_reg <= 1'b1;
        end else if (out_ready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ack) begin
            out_status_reg <= cmd.ack_status;
            out_start_reg  <= '0;
            out_end_reg    <= '0;
            out_occ_reg    <= '0;
            out_last_reg   <= 1'b1;
            out_ovf_reg    <= 1'b0;
        end else if (cmd.sweep_step && store && pend_v_reg) begin
            out_status_reg <= pend_occ_reg[sosi_pkg::CNT_W-1] ? sosi_pkg::STAT_NEG
                                                              : sosi_pkg::STAT_OK;
            out_start_reg  <= pend_start_reg;
            out_end_reg    <= pend_end_reg;
            out_occ_reg    <= pend_occ_reg;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end else if (cmd.finish) begin
            out_last_reg <= 1'b1;
            if (kind_reg != sosi_pkg::KIND_SAFE) begin
                out_status_reg <= cnt_reg[sosi_pkg::CNT_W-1] ? sosi_pkg::STAT_NEG
                                                             : sosi_pkg::STAT_OK;
                out_start_reg  <= '0;
                out_end_reg    <= '0;
                out_occ_reg    <= cnt_reg;
                out_ovf_reg    <= 1'b0;
            end else if (pend_v_reg) begin
                out_status_reg <= pend_occ_reg[sosi_pkg::CNT_W-1] ? sosi_pkg::STAT_NEG
                                                                  : sosi_pkg::STAT_OK;
                out_start_reg  <= pend_start_reg;
                out_end_reg    <= pend_end_reg;
                out_occ_reg    <= pend_occ_reg;
                out_ovf_reg    <= ovf_reg;
            end else begin
                out_status_reg <= sosi_pkg::STAT_NONE;
                out_start_reg  <= '0;
                out_end_reg    <= '0;
                out_occ_reg    <= '0;
                out_ovf_reg    <= 1'b0;
            end
        end
    end

    assign out_valid  = out_v_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_start_reg;
    assign out_end    = out_end_reg;
    assign out_occ    = out_occ_reg;
    assign out_last   = out_last_reg;
    assign out_ovf    = out_ovf_reg;

endmodule

### rtl/section_occupancy_safe_intervals.sv
// Occupancy-change store for 64 sections by 1024 time slots, held in one RAM with a
// single read and a single write port. After reset, and for every clear item, a
// clearing pass writes zero to all 65536 entries, one a cycle, while s_tready is low;
// a clear is acknowledged when the pass ends. Path steps and ends of path are
// read-modify-write updates of up to two entries. A safe query walks the section's
// slots 0 to L (L is time_limit, at least 1), one slot per cycle through the RAM read
// port while the result side does not stall; a congestion query walks slots 0 to
// time_req. One item is worked on at a time, and the next is taken while the last
// result still waits on the master side.
module section_occupancy_safe_intervals (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // section[5:0], time_req[15:6], capacity[24:16]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // interval_start[9:0], interval_end[19:10], occupancy[29:20]
    output logic [2:0]  m_tuser,   // status[1:0], overflow[2]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data
);

    sosi_pkg::cmd_t                    cmd;
    sosi_pkg::stat_t                   stat;
    logic [1:0]                        out_status;
    logic [sosi_pkg::TIME_W-1:0]       out_start;
    logic [sosi_pkg::TIME_W-1:0]       out_end;
    logic [sosi_pkg::CNT_W-1:0]        out_occ;
    logic                              out_ovf;

    sosi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sosi_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser),
        .in_section  (s_tdata[5:0]),
        .in_time     (s_tdata[15:6]),
        .in_capacity (s_tdata[24:16]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_start   (out_start),
        .out_end     (out_end),
        .out_occ     (out_occ),
        .out_last    (m_tlast),
        .out_ovf     (out_ovf)
    );

    assign m_tdata = {2'b00, out_occ, out_end, out_start};
    assign m_tuser = {out_ovf, out_status};

endmodule

### rtl/sosi_checker.sv
`include "section_occupancy_safe_intervals_defines.svh"

module sosi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A waiting transaction is not withdrawn.
    `SOSI_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)
    // A query with no safe interval answers with a single, final transaction.
    `SOSI_ASSERT(a_none_last, m_tvalid && (m_tuser[1:0] == sosi_pkg::STAT_NONE) |-> m_tlast)
    // Overflow is reported only on the final interval of a query.
    `SOSI_ASSERT(a_ovf_last, m_tvalid && m_tuser[2] |-> m_tlast)
    // Reset empties the result side and starts the clearing pass.
    `SOSI_ASSERT_ALWAYS(a_rst_out, !aresetn |=> !m_tvalid)
    `SOSI_ASSERT_ALWAYS(a_rst_busy, !aresetn |=> !s_tready)

endmodule

bind section_occupancy_safe_intervals sosi_checker u_sosi_checker (.*);
